// ----- rtl/nfa_word_acceptor_unit_defines.svh -----
// Assertion macros shared by the NFA acceptor RTL.
`ifndef NFA_WORD_ACCEPTOR_UNIT_DEFINES_SVH
`define NFA_WORD_ACCEPTOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge out of reset
`define NFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nfa acceptor: same-cycle check failed");

// Next-cycle implication
`define NFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nfa acceptor: next-cycle check failed");

`endif

// ----- rtl/nfa_pkg.sv -----
// Types, sizes and helpers shared by the NFA acceptor modules.
package nfa_pkg;

  // Automaton and table sizes
  localparam int STATES      = 64;
  localparam int TRANSITIONS = 128;

  // Fixed field widths
  localparam int STATE_W = 6;
  localparam int SYM_W   = 8;
  localparam int SLOT_W  = 7;
  localparam int SET_W   = 64;

  // Table scan: LANES slots compared per cycle, ROWS rows per scan
  localparam int LANES   = 16;
  localparam int LANE_AW = $clog2(LANES);
  localparam int ROWS    = (TRANSITIONS + LANES - 1) / LANES;
  localparam int ROW_AW  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int ROW_CW  = $clog2(ROWS + 1);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int Q_AW        = $clog2(QUEUE_DEPTH);
  localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

  // Bits of a stored transition (valid bit kept in flops)
  localparam int ENTRY_W = 2 * STATE_W + SYM_W;

  // States at or above STATES are dropped from every set
  localparam logic [SET_W-1:0] SET_LIMIT =
    (STATES >= SET_W) ? {SET_W{1'b1}} : ((SET_W'(1) << STATES) - SET_W'(1));

  // Request types
  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SYMBOL = 1'b1;

  // Configuration register indexes
  localparam int CFG_AW = 1;
  localparam logic [CFG_AW-1:0] CFG_START_STATE = 1'b0;
  localparam logic [CFG_AW-1:0] CFG_FINAL_MASK  = 1'b1;

  // One stored transition
  typedef struct packed {
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   label;
  } nfa_edge_t;

  // Classified item as it travels through the queue
  typedef struct packed {
    logic               is_sym;
    logic               slot_ok;
    logic [ROW_AW-1:0]  row;
    logic [LANE_AW-1:0] lane;
    logic               slot_valid;
    nfa_edge_t          edge_data;
    logic [SYM_W-1:0]   symbol;
    logic               last;
  } nfa_item_t;

  // Back end sequencer states
  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SCAN = 2'b10
  } nfa_back_state_t;

  // One-hot bit of a state, masked to the automaton size
  function automatic logic [SET_W-1:0] state_bit(input logic [STATE_W-1:0] s);
    state_bit = (SET_W'(1) << s) & SET_LIMIT;
  endfunction

endpackage

// ----- rtl/nfa_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- rtl/nfa_front.sv -----
// Front end: accepts items, classifies them and queues them for the back end.
module nfa_front import nfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic               in_slot_valid,
  input  logic [STATE_W-1:0] in_from_state,
  input  logic [STATE_W-1:0] in_to_state,
  input  logic [SYM_W-1:0]   in_label,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic               in_last_symbol,
  output nfa_item_t          q_item,
  output logic               q_valid,
  input  logic               q_pop
);

  nfa_item_t          item_r [QUEUE_DEPTH];
  nfa_item_t          item_nxt;
  logic [Q_AW-1:0]    wr_ptr_r;
  logic [Q_AW-1:0]    rd_ptr_r;
  logic [Q_CW-1:0]    cnt_r;
  logic               push;

  assign busy    = (cnt_r == Q_CW'(QUEUE_DEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_item  = item_r[rd_ptr_r];

  // Classify the incoming beat
  always_comb begin
    item_nxt                      = '0;
    item_nxt.is_sym               = (in_req_type == REQ_SYMBOL);
    item_nxt.slot_ok              = (int'(in_slot) < TRANSITIONS);
    item_nxt.row                  = ROW_AW'(in_slot >> LANE_AW);
    item_nxt.lane                 = in_slot[LANE_AW-1:0];
    item_nxt.slot_valid           = in_slot_valid;
    item_nxt.edge_data.from_state = in_from_state;
    item_nxt.edge_data.to_state   = in_to_state;
    item_nxt.edge_data.label      = in_label;
    item_nxt.symbol               = in_symbol;
    item_nxt.last                 = in_last_symbol;
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      item_r[wr_ptr_r] <= item_nxt;
    end
  end

  // Queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + Q_AW'(1);
      end
      if (q_pop) begin
        rd_ptr_r <= rd_ptr_r + Q_AW'(1);
      end
      if (push && !q_pop) begin
        cnt_r <= cnt_r + Q_CW'(1);
      end else if (!push && q_pop) begin
        cnt_r <= cnt_r - Q_CW'(1);
      end
    end
  end

endmodule

// ----- rtl/nfa_back.sv -----
// Back end: writes table slots and scans the table to advance the active set.
module nfa_back import nfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  nfa_item_t          q_item,
  input  logic               q_valid,
  output logic               q_pop,
  input  logic [STATE_W-1:0] start_state,
  input  logic [SET_W-1:0]   final_mask,
  output logic               out_strobe,
  output logic               out_accepted,
  output logic               out_dead
);

  nfa_back_state_t     state_r;
  logic [LANES-1:0]    valid_r [ROWS];
  logic [LANES-1:0]    vrow_r;
  logic [ROW_CW-1:0]   row_r;
  logic                rd_vld_r;
  logic                rd_last_r;
  logic                word_open_r;
  logic [SET_W-1:0]    active_r;
  logic [SET_W-1:0]    cur_r;
  logic [SET_W-1:0]    next_r;
  logic [SET_W-1:0]    next_nxt;
  logic [SET_W-1:0]    step_set;
  logic [SYM_W-1:0]    sym_r;
  logic                last_r;
  logic                out_strobe_r;
  logic                out_accepted_r;
  logic                out_dead_r;
  logic                rd_en;
  logic [ROW_AW-1:0]   rd_addr;
  logic                rd_last;
  logic                do_write;
  logic                take_sym;
  logic                scan_done;
  logic [ENTRY_W-1:0]  bank_q [LANES];

  assign q_pop     = (state_r == B_IDLE) && q_valid;
  assign do_write  = q_pop && !q_item.is_sym && q_item.slot_ok;
  assign take_sym  = q_pop && q_item.is_sym;
  assign scan_done = rd_vld_r && rd_last_r;

  assign out_strobe   = out_strobe_r;
  assign out_accepted = out_accepted_r;
  assign out_dead     = out_dead_r;

  // Row read issue: row 0 goes out with the pop, the rest from the counter
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    unique case (state_r)
      B_IDLE: begin
        rd_en   = take_sym;
        rd_addr = '0;
      end
      B_SCAN: begin
        rd_en   = (row_r != ROW_CW'(ROWS));
        rd_addr = row_r[ROW_AW-1:0];
      end
      default: begin
        rd_en   = 1'b0;
        rd_addr = '0;
      end
    endcase
  end
  assign rd_last = (rd_addr == ROW_AW'(ROWS - 1));

  // Transition banks, one per lane
  for (genvar g = 0; g < LANES; g++) begin : g_bank
    nfa_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ROWS)
    ) u_bank (
      .clk   (clk),
      .we    (do_write && (q_item.lane == LANE_AW'(g))),
      .waddr (q_item.row),
      .wdata (q_item.edge_data),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (bank_q[g])
    );
  end

  // Lane compare: fire every valid edge from an active state on this symbol
  always_comb begin
    nfa_edge_t e;
    step_set = '0;
    for (int g = 0; g < LANES; g++) begin
      e = nfa_edge_t'(bank_q[g]);
      if (vrow_r[g] && (e.label == sym_r) && cur_r[e.from_state]) begin
        step_set = step_set | state_bit(e.to_state);
      end
    end
  end
  assign next_nxt = next_r | step_set;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      row_r        <= '0;
      rd_vld_r     <= 1'b0;
      rd_last_r    <= 1'b0;
      word_open_r  <= 1'b0;
      active_r     <= '0;
      out_strobe_r <= 1'b0;
      for (int r = 0; r < ROWS; r++) begin
        valid_r[r] <= '0;
      end
    end else begin
      out_strobe_r <= 1'b0;
      rd_vld_r     <= rd_en;
      rd_last_r    <= rd_en && rd_last;
      if (do_write) begin
        valid_r[q_item.row][q_item.lane] <= q_item.slot_valid;
      end
      unique case (state_r)
        B_IDLE: begin
          if (take_sym) begin
            row_r   <= ROW_CW'(1);
            state_r <= B_SCAN;
          end
        end
        B_SCAN: begin
          if (rd_en) begin
            row_r <= row_r + ROW_CW'(1);
          end
          if (scan_done) begin
            state_r <= B_IDLE;
            if (last_r) begin
              out_strobe_r <= 1'b1;
              word_open_r  <= 1'b0;
              active_r     <= state_bit(start_state);
            end else begin
              word_open_r  <= 1'b1;
              active_r     <= next_nxt;
            end
          end
        end
        default: begin
          state_r <= B_IDLE;
        end
      endcase
    end
  end

  // Scan datapath and result fields
  always_ff @(posedge clk) begin
    vrow_r <= valid_r[rd_addr];
    if (take_sym) begin
      sym_r  <= q_item.symbol;
      last_r <= q_item.last;
      cur_r  <= word_open_r ? active_r : state_bit(start_state);
      next_r <= '0;
    end else if (rd_vld_r) begin
      next_r <= next_nxt;
    end
    if (scan_done) begin
      out_accepted_r <= ((next_nxt & final_mask) != '0);
      out_dead_r     <= (next_nxt == '0);
    end
  end

endmodule

// ----- rtl/nfa_word_acceptor_unit.sv -----
// NFA word acceptor: a symbol is handled in the back end by a scan over all ROWS = 8 rows:
// the table is scanned 16 slots a cycle from 16 lane RAM banks, one row per cycle.
// A load is written in the back end as it is popped; a two-beat queue lets start be taken while a scan runs.
// The result strobes once an accepted last symbol has been popped and its scan has finished.
// Synchronous active-low reset clears config, active set, queue and all slot valid bits.
// Results cannot be stalled: out_strobe is high for exactly one cycle per word.
`include "nfa_word_acceptor_unit_defines.svh"

module nfa_word_acceptor_unit import nfa_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_req_type,
  input  logic [SLOT_W-1:0]  in_slot,
  input  logic               in_slot_valid,
  input  logic [STATE_W-1:0] in_from_state,
  input  logic [STATE_W-1:0] in_to_state,
  input  logic [SYM_W-1:0]   in_label,
  input  logic [SYM_W-1:0]   in_symbol,
  input  logic               in_last_symbol,
  output logic               out_strobe,
  output logic               out_accepted,
  output logic               out_dead,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [CFG_AW-1:0]  cfg_index,
  input  logic [SET_W-1:0]   cfg_data
);

  logic [STATE_W-1:0] start_state_r;
  logic [SET_W-1:0]   final_mask_r;
  nfa_item_t          q_item;
  logic               q_valid;
  logic               q_pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_state_r <= '0;
      final_mask_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_STATE: start_state_r <= cfg_data[STATE_W-1:0];
        CFG_FINAL_MASK:  final_mask_r  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  nfa_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_slot_valid  (in_slot_valid),
    .in_from_state  (in_from_state),
    .in_to_state    (in_to_state),
    .in_label       (in_label),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_pop          (q_pop)
  );

  nfa_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_item       (q_item),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .start_state  (start_state_r),
    .final_mask   (final_mask_r),
    .out_strobe   (out_strobe),
    .out_accepted (out_accepted),
    .out_dead     (out_dead)
  );

  // Results are spaced by a full scan, so no strobe follows straight on another
  `NFA_ASSERT_NEXT(a_strobe_single, out_strobe, !out_strobe)
  // An accepted word always has a surviving state
  `NFA_ASSERT_NOW(a_accept_not_dead, out_strobe, !(out_accepted && out_dead))
  // An accepted beat is in the queue on the next cycle
  `NFA_ASSERT_NEXT(a_push_queued, start && !busy, q_valid)

endmodule

// ----- tb/sv/nfa_word_acceptor_unit_tb.sv -----
// Self-checking testbench for the NFA word acceptor: table loads, words and verdict checks.
`timescale 1ns / 100ps

module nfa_word_acceptor_unit_tb;
  import nfa_pkg::*;

  // One input beat as the driver presents it
  typedef struct {
    logic               req_type;
    logic [SLOT_W-1:0]  slot;
    logic               slot_valid;
    logic [STATE_W-1:0] from_state;
    logic [STATE_W-1:0] to_state;
    logic [SYM_W-1:0]   label;
    logic [SYM_W-1:0]   symbol;
    logic               last_symbol;
  } nfa_req_t;

  // Verdict of one finished word
  typedef struct packed {
    logic accepted;
    logic dead;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_req_type = 1'b0;
  logic [SLOT_W-1:0] in_slot = '0;
  logic in_slot_valid = 1'b0;
  logic [STATE_W-1:0] in_from_state = '0;
  logic [STATE_W-1:0] in_to_state = '0;
  logic [SYM_W-1:0] in_label = '0;
  logic [SYM_W-1:0] in_symbol = '0;
  logic in_last_symbol = 1'b0;
  logic out_strobe;
  logic out_accepted;
  logic out_dead;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_AW-1:0] cfg_index = '0;
  logic [SET_W-1:0] cfg_data = '0;

  // Beats waiting for the driver, verdicts waiting for the monitor
  nfa_req_t pending[$];
  verdict_t verdicts_due[$];

  // Predictor state: register shadows, active set, transition table
  logic [STATE_W-1:0] start_shadow = '0;
  logic [SET_W-1:0]   final_shadow = '0;
  logic [SET_W-1:0]   live_set = '0;
  logic               word_live = 1'b0;
  logic               arc_valid [TRANSITIONS];
  logic [STATE_W-1:0] arc_from [TRANSITIONS];
  logic [STATE_W-1:0] arc_to [TRANSITIONS];
  logic [SYM_W-1:0]   arc_label [TRANSITIONS];

  // Bookkeeping
  int mismatches = 0;
  int beats_fed = 0;
  int verdicts_seen = 0;
  int accepts_seen = 0;
  int deads_seen = 0;
  int cfg_writes = 0;
  int queued_total = 0;
  bit gaps_on = 1'b1;
  int gap_left = 0;
  nfa_req_t drv_item;

  nfa_word_acceptor_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_req_type    (in_req_type),
    .in_slot        (in_slot),
    .in_slot_valid  (in_slot_valid),
    .in_from_state  (in_from_state),
    .in_to_state    (in_to_state),
    .in_label       (in_label),
    .in_symbol      (in_symbol),
    .in_last_symbol (in_last_symbol),
    .out_strobe     (out_strobe),
    .out_accepted   (out_accepted),
    .out_dead       (out_dead),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #6 clk = ~clk;

  initial begin
    for (int i = 0; i < TRANSITIONS; i++) begin
      arc_valid[i] = 1'b0;
      arc_from[i] = '0;
      arc_to[i] = '0;
      arc_label[i] = '0;
    end
  end

  // Advance the predicted automaton by one accepted beat
  task automatic nfa_advance(input nfa_req_t it);
    logic [SET_W-1:0] from_set;
    logic [SET_W-1:0] next_set;
    verdict_t v;
    if (it.req_type == REQ_LOAD) begin
      if (int'(it.slot) < TRANSITIONS) begin
        arc_valid[it.slot] = it.slot_valid;
        arc_from[it.slot] = it.from_state;
        arc_to[it.slot] = it.to_state;
        arc_label[it.slot] = it.label;
      end
    end else begin
      // first symbol of a word starts from the start state alone
      from_set = word_live ? live_set : ((SET_W'(1) << start_shadow) & SET_LIMIT);
      next_set = '0;
      for (int i = 0; i < TRANSITIONS; i++) begin
        if (arc_valid[i] && arc_label[i] == it.symbol && from_set[arc_from[i]])
          next_set[arc_to[i]] = 1'b1;
      end
      live_set = next_set & SET_LIMIT;
      word_live = 1'b1;
      if (it.last_symbol) begin
        v.accepted = |(live_set & final_shadow);
        v.dead = (live_set == '0);
        verdicts_due = {verdicts_due, v};
        word_live = 1'b0;
        live_set = (SET_W'(1) << start_shadow) & SET_LIMIT;
      end
    end
  endtask

  // Idle length before the next beat: mostly none or short, a few long
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Driver: holds a beat until start && !busy, then predicts it
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        nfa_advance(drv_item);
        beats_fed++;
        gap_left = draw_gap();
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending.size() > 0) begin
          drv_item = pending.pop_front();
          in_req_type <= drv_item.req_type;
          in_slot <= drv_item.slot;
          in_slot_valid <= drv_item.slot_valid;
          in_from_state <= drv_item.from_state;
          in_to_state <= drv_item.to_state;
          in_label <= drv_item.label;
          in_symbol <= drv_item.symbol;
          in_last_symbol <= drv_item.last_symbol;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobe is one verdict, checked against the oldest due
  always @(posedge clk) begin
    verdict_t v;
    if (rst_n && out_strobe) begin
      verdicts_seen++;
      if (out_accepted) accepts_seen++;
      if (out_dead) deads_seen++;
      if (verdicts_due.size() == 0) begin
        $error("verdict with none due: accepted=%0b dead=%0b", out_accepted, out_dead);
        mismatches++;
      end else begin
        v = verdicts_due.pop_front();
        if (out_accepted !== v.accepted) begin
          $error("accepted: expected %0b, got %0b", v.accepted, out_accepted);
          mismatches++;
        end
        if (out_dead !== v.dead) begin
          $error("dead: expected %0b, got %0b", v.dead, out_dead);
          mismatches++;
        end
      end
    end
  end

  // Register write over the cfg channel; shadows follow at the handshake
  task automatic write_reg(input logic [CFG_AW-1:0] idx, input logic [SET_W-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_START_STATE) start_shadow = val[STATE_W-1:0];
    else final_shadow = val;
    cfg_writes++;
  endtask

  task automatic set_regs(input logic [STATE_W-1:0] st, input logic [SET_W-1:0] fm);
    // unused high bits of the start register carry noise
    write_reg(CFG_START_STATE, {$urandom, 26'($urandom), 6'd0} | SET_W'(st));
    write_reg(CFG_FINAL_MASK, fm);
  endtask

  task automatic add_load(input logic [SLOT_W-1:0] sl, input logic vl,
                          input logic [STATE_W-1:0] fr, input logic [STATE_W-1:0] to,
                          input logic [SYM_W-1:0] lb);
    nfa_req_t it;
    it.req_type = REQ_LOAD;
    it.slot = sl;
    it.slot_valid = vl;
    it.from_state = fr;
    it.to_state = to;
    it.label = lb;
    it.symbol = SYM_W'($urandom_range(0, 255));
    it.last_symbol = 1'($urandom_range(0, 1));
    pending = {pending, it};
    queued_total++;
  endtask

  task automatic add_symbol(input logic [SYM_W-1:0] sy, input logic lst);
    nfa_req_t it;
    it.req_type = REQ_SYMBOL;
    it.slot = SLOT_W'($urandom_range(0, 127));
    it.slot_valid = 1'($urandom_range(0, 1));
    it.from_state = STATE_W'($urandom_range(0, 63));
    it.to_state = STATE_W'($urandom_range(0, 63));
    it.label = SYM_W'($urandom_range(0, 255));
    it.symbol = sy;
    it.last_symbol = lst;
    pending = {pending, it};
    queued_total++;
  endtask

  // Hold until the block has drained, plus room for loads still in its queue
  task automatic drain();
    while (pending.size() != 0 || start || verdicts_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // Random phase: a small automaton around the start state, then words over it
  task automatic random_phase(input int n);
    logic [STATE_W-1:0] pool [5];
    logic [SYM_W-1:0]   alpha [3];
    int goal;
    int r;
    int len;
    bit open;
    goal = queued_total + n;
    open = 1'b0;
    pool[0] = start_shadow;
    for (int i = 1; i < 5; i++) pool[i] = STATE_W'($urandom_range(0, 63));
    for (int i = 0; i < 3; i++) alpha[i] = SYM_W'($urandom_range(0, 255));
    for (int i = 0; i < 16; i++)
      add_load(SLOT_W'($urandom_range(0, 127)), $urandom_range(0, 9) != 0,
               pool[3'($urandom_range(0, 4))], pool[3'($urandom_range(0, 4))],
               alpha[2'($urandom_range(0, 2))]);
    while (queued_total < goal) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise load
        add_load(SLOT_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)),
                 STATE_W'($urandom_range(0, 63)), STATE_W'($urandom_range(0, 63)),
                 SYM_W'($urandom_range(0, 255)));
      end else if (r < 12) begin
        // stray symbol, may leave a word open
        open = 1'($urandom_range(0, 1));
        add_symbol(SYM_W'($urandom_range(0, 255)), !open);
      end else if (r < 17) begin
        // edit the automaton, possibly mid-word
        add_load(SLOT_W'($urandom_range(0, 127)), $urandom_range(0, 3) != 0,
                 pool[3'($urandom_range(0, 4))], pool[3'($urandom_range(0, 4))],
                 alpha[2'($urandom_range(0, 2))]);
      end else begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++)
          add_symbol(($urandom_range(0, 9) != 0) ? alpha[2'($urandom_range(0, 2))]
                                                 : SYM_W'($urandom_range(0, 255)),
                     k == len - 1);
        open = 1'b0;
      end
    end
    if (open) add_symbol(alpha[2'($urandom_range(0, 2))], 1'b1);
  endtask

  // Main sequence
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes of slots and states, clears, empty sets, mid-word loads
    set_regs(6'd0, {1'b1, 62'd0, 1'b1});
    add_load(7'd0, 1'b1, 6'd0, 6'd63, 8'hFF);
    add_load(7'd127, 1'b1, 6'd63, 6'd0, 8'h00);
    add_load(7'd5, 1'b1, 6'd0, 6'd0, 8'h55);
    add_symbol(8'hFF, 1'b1);
    add_symbol(8'hFF, 1'b0);
    add_symbol(8'h00, 1'b1);
    add_symbol(8'h12, 1'b1);
    add_symbol(8'h12, 1'b0);
    add_symbol(8'hFF, 1'b0);
    add_symbol(8'h00, 1'b1);
    add_symbol(8'h55, 1'b0);
    add_load(7'd6, 1'b1, 6'd0, 6'd1, 8'h55);
    add_symbol(8'h55, 1'b1);
    add_load(7'd0, 1'b0, 6'd0, 6'd63, 8'hFF);
    add_symbol(8'hFF, 1'b1);
    add_load(7'd64, 1'b1, 6'd42, 6'd21, 8'hAA);
    drain();

    // Random phases, each under its own register setting
    for (int p = 0; p < 6; p++) begin
      gaps_on = (p != 2);
      case (p)
        0: set_regs(6'd63, {SET_W{1'b1}});
        1: set_regs(STATE_W'($urandom_range(0, 63)), '0);
        3: set_regs(6'd0, SET_W'(1) << $urandom_range(0, 63));
        default: set_regs(STATE_W'($urandom_range(0, 63)), {$urandom, $urandom});
      endcase
      random_phase(90);
      drain();
    end

    $display("Ran %0d beats under %0d register writes;", beats_fed, cfg_writes);
    $display("%0d words judged, %0d accepted, %0d dead.",
             verdicts_seen, accepts_seen, deads_seen);
    if (mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  // Watchdog
  initial begin
    #(8_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl
rtl/nfa_pkg.sv
rtl/nfa_ram.sv
rtl/nfa_front.sv
rtl/nfa_back.sv
rtl/nfa_word_acceptor_unit.sv
tb/sv/nfa_word_acceptor_unit_tb.sv
